// ===== rtl/gpio_irq_pkg.sv =====
// Shared types, codes and helper functions for the GPIO bank with pin-change interrupts.
// No dependencies; the interfaces and the top level import this package.
package gpio_irq_pkg;

	typedef enum logic [2:0] {
		REQ_SET_MODE = 3'd0,
		REQ_DIG_WR   = 3'd1,
		REQ_READ     = 3'd2,
		REQ_ANA_WR   = 3'd3,
		REQ_TOGGLE   = 3'd4,
		REQ_SERVICE  = 3'd5
	} req_type_t;

	typedef enum logic [1:0] {
		PM_NONE   = 2'd0,
		PM_INPUT  = 2'd1,
		PM_OUTPUT = 2'd2,
		PM_PULLUP = 2'd3
	} pin_mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_BAD_MODE  = 2'd2,
		ST_BAD_VALUE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		LM_NONE    = 3'd0,
		LM_LOW     = 3'd1,
		LM_HIGH    = 3'd2,
		LM_RISING  = 3'd3,
		LM_FALLING = 3'd4,
		LM_CHANGE  = 3'd5
	} line_mode_t;

	localparam int unsigned PIN_W      = 6;
	localparam int unsigned LINE_W     = 3;
	localparam int unsigned LEVEL_W    = 8;
	localparam int unsigned VALUE_W    = 16;
	localparam int unsigned COUNT_W    = 5;
	localparam int unsigned NUM_LINES  = 6;
	localparam int unsigned MODES_W    = NUM_LINES * LINE_W;
	localparam int unsigned LEVEL_MAX  = 255;

	localparam logic [PIN_W-1:0] PIN_LINE0 = 6'd2;
	localparam logic [PIN_W-1:0] PIN_LINE1 = 6'd3;
	localparam logic [PIN_W-1:0] PIN_LINE2 = 6'd18;
	localparam logic [PIN_W-1:0] PIN_LINE3 = 6'd19;
	localparam logic [PIN_W-1:0] PIN_LINE4 = 6'd20;
	localparam logic [PIN_W-1:0] PIN_LINE5 = 6'd21;

	typedef struct packed {
		pin_mode_t            mode;
		logic                 analog;
		logic [LEVEL_W-1:0]   level;
	} pin_ent_t;

	typedef struct packed {
		logic                 valid;
		logic [LINE_W-1:0]    line;
	} pin_line_t;

	function automatic pin_line_t line_of_pin(input logic [PIN_W-1:0] pin);
		pin_line_t pl;
		pl = '0;
		unique case (pin)
			PIN_LINE0: pl = '{valid: 1'b1, line: 3'd0};
			PIN_LINE1: pl = '{valid: 1'b1, line: 3'd1};
			PIN_LINE2: pl = '{valid: 1'b1, line: 3'd2};
			PIN_LINE3: pl = '{valid: 1'b1, line: 3'd3};
			PIN_LINE4: pl = '{valid: 1'b1, line: 3'd4};
			PIN_LINE5: pl = '{valid: 1'b1, line: 3'd5};
			default:   pl = '0;
		endcase
		return pl;
	endfunction

	function automatic line_mode_t line_mode_of(input logic [MODES_W-1:0] modes,
		input logic [LINE_W-1:0] line);
		logic [LINE_W-1:0] lm;
		lm = '0;
		unique case (line)
			3'd0:    lm = modes[2:0];
			3'd1:    lm = modes[5:3];
			3'd2:    lm = modes[8:6];
			3'd3:    lm = modes[11:9];
			3'd4:    lm = modes[14:12];
			3'd5:    lm = modes[17:15];
			default: lm = '0;
		endcase
		return line_mode_t'(lm);
	endfunction

	function automatic logic [LEVEL_W-1:0] clamp_level(input logic signed [VALUE_W-1:0] v);
		logic [LEVEL_W-1:0] r;
		r = '0;
		priority if (v < 0)
			r = '0;
		else if (v > $signed(VALUE_W'(LEVEL_MAX)))
			r = LEVEL_W'(LEVEL_MAX);
		else
			r = v[LEVEL_W-1:0];
		return r;
	endfunction

endpackage

// ===== rtl/gpio_irq_req_if.sv =====
// Request channel of the GPIO bank: valid/ready handshake with the request fields.
// Depends on gpio_irq_pkg for field widths.
interface gpio_irq_req_if
	import gpio_irq_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic [2:0]                 req_type;
	logic [PIN_W-1:0]           pin_index;
	logic [1:0]                 new_mode;
	logic signed [VALUE_W-1:0]  write_value;

	modport source (output valid, req_type, pin_index, new_mode, write_value, input ready);
	modport sink   (input valid, req_type, pin_index, new_mode, write_value, output ready);
endinterface

// ===== rtl/gpio_irq_rsp_if.sv =====
// Result channel of the GPIO bank: valid/ready handshake with the result fields.
// Depends on gpio_irq_pkg for field widths.
interface gpio_irq_rsp_if
	import gpio_irq_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [1:0]            status;
	logic [LEVEL_W-1:0]    read_level;
	logic                  read_is_analog;
	logic                  irq_valid;
	logic [LINE_W-1:0]     irq_line;
	logic                  irq_dropped;
	logic [COUNT_W-1:0]    pending_count;
	logic                  pin_line_valid;
	logic [LINE_W-1:0]     pin_line;

	modport source (output valid, status, read_level, read_is_analog, irq_valid, irq_line,
		irq_dropped, pending_count, pin_line_valid, pin_line, input ready);
	modport sink   (input valid, status, read_level, read_is_analog, irq_valid, irq_line,
		irq_dropped, pending_count, pin_line_valid, pin_line, output ready);
endinterface

// ===== rtl/gpio_bank_with_pin_interrupts.sv =====
// Top level of the GPIO bank with pin-change interrupts: pin table, event queue, handshakes.
// Depends on gpio_irq_pkg, gpio_irq_req_if and gpio_irq_rsp_if.
//
// Each request is a mode change, digital or analog write, read, external toggle or an
// interrupt service; one result comes back for every request. The block takes one request
// per clock while rsp.ready does not hold the result: stage 1 registers the request and reads
// the pin entry, and processing stage 1 applies the read-modify-write to the pin table and
// event queue and loads the result register. A result held by a low rsp.ready holds stage 1
// and blocks the request channel. The pin table resets to mode none, level zero by per-entry
// valid bits, so no clearing pass is needed. Pins 2, 3, 18, 19, 20 and 21 are interrupt lines
// 0 to 5; only external toggles on them queue events, as set by cfg_wdata (three bits per
// line). Events beyond QUEUE_DEPTH are dropped and reported in irq_dropped. Write the line
// modes only while no request is in flight.
module gpio_bank_with_pin_interrupts
	import gpio_irq_pkg::*;
#(
	parameter int unsigned NUM_PINS    = 64,
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	gpio_irq_req_if.sink        req,
	gpio_irq_rsp_if.source      rsp,
	input  logic                cfg_we,
	input  logic [MODES_W-1:0]  cfg_wdata
);

	localparam int unsigned DEPTH   = (NUM_PINS < 64) ? NUM_PINS : 64;
	localparam int unsigned ADDR_W  = $clog2(DEPTH);
	localparam bit          ALL_IN  = (NUM_PINS >= 64);
	localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);

	// configuration
	logic [MODES_W-1:0] line_modes_q;

	// stage 1: registered request and pin entry
	logic                       valid_s1;
	req_type_t                  req_s1;
	logic [PIN_W-1:0]           pin_s1;
	pin_mode_t                  nmode_s1;
	logic signed [VALUE_W-1:0]  val_s1;
	pin_ent_t                   ent_s1;
	logic                       ent_vld_s1;

	// pin table
	pin_ent_t                   pin_mem [DEPTH];
	logic [DEPTH-1:0]           pin_vld_q;

	// event queue
	logic [LINE_W-1:0]          fifo_mem [QUEUE_DEPTH];
	logic [LINE_W-1:0]          fifo_rd_q;
	logic [PTR_W-1:0]           head_q;
	logic [PTR_W-1:0]           tail_q;
	logic [CNT_W-1:0]           count_q;

	// result register
	logic                       out_valid_q;
	status_t                    status_q;
	logic [LEVEL_W-1:0]         rlevel_q;
	logic                       ranalog_q;
	logic                       ivalid_q;
	logic [LINE_W-1:0]          iline_q;
	logic                       dropped_q;
	logic [COUNT_W-1:0]         pending_q;
	pin_line_t                  pl_q;

	// datapath
	logic                       adv;
	logic                       process;
	logic                       accept;
	logic                       in_range;
	pin_ent_t                   ent;
	pin_ent_t                   ent_nxt;
	logic                       ent_we;
	logic [ADDR_W-1:0]          waddr;
	logic [ADDR_W-1:0]          raddr;
	pin_line_t                  pl;
	line_mode_t                 lm;
	logic                       nv;
	logic                       fire;
	logic                       push;
	logic                       pop;
	logic                       dropped;
	status_t                    status;
	logic [LEVEL_W-1:0]         rlevel;
	logic                       ranalog;
	logic [CNT_W-1:0]           count_d;
	logic [PTR_W-1:0]           head_inc;
	logic [PTR_W-1:0]           tail_inc;
	logic [PTR_W-1:0]           head_nxt;

	assign adv      = !out_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || adv;
	assign accept   = req.valid && req.ready;
	assign process  = valid_s1 && adv;

	assign waddr    = pin_s1[ADDR_W-1:0];
	assign raddr    = req.pin_index[ADDR_W-1:0];
	assign in_range = ALL_IN || (pin_s1 < PIN_W'(DEPTH));
	assign ent      = ent_vld_s1 ? ent_s1 : '0;
	assign pl       = line_of_pin(pin_s1);
	assign lm       = line_mode_of(line_modes_q, pl.line);
	assign nv       = (ent.level == '0);

	assign head_inc = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign head_nxt = pop ? head_inc : head_q;

	always_comb begin
		ent_nxt = ent;
		ent_we  = 1'b0;
		status  = ST_OK;
		rlevel  = '0;
		ranalog = 1'b0;
		fire    = 1'b0;
		pop     = 1'b0;
		priority if (req_s1 <= REQ_TOGGLE && !in_range) begin
			status = ST_RANGE;
		end else begin
			unique case (req_s1)
				REQ_SET_MODE: begin
					ent_nxt.mode = nmode_s1;
					ent_we       = 1'b1;
					if (nmode_s1 == PM_PULLUP)
						ent_nxt.level = ent.analog ? '0 : LEVEL_W'(nv);
				end
				REQ_DIG_WR: begin
					if (ent.mode != PM_OUTPUT) begin
						status = ST_BAD_MODE;
					end else if (val_s1 != 0 && val_s1 != 1) begin
						status = ST_BAD_VALUE;
					end else begin
						ent_nxt.level  = LEVEL_W'(val_s1[0]);
						ent_nxt.analog = 1'b0;
						ent_we         = 1'b1;
					end
				end
				REQ_READ: begin
					if (ent.mode != PM_INPUT && ent.mode != PM_PULLUP) begin
						status = ST_BAD_MODE;
					end else begin
						rlevel  = ent.level;
						ranalog = ent.analog;
					end
				end
				REQ_ANA_WR: begin
					if (ent.mode != PM_OUTPUT) begin
						status = ST_BAD_MODE;
					end else begin
						ent_nxt.level  = clamp_level(val_s1);
						ent_nxt.analog = 1'b1;
						ent_we         = 1'b1;
					end
				end
				REQ_TOGGLE: begin
					ent_nxt.level  = LEVEL_W'(nv);
					ent_nxt.analog = 1'b0;
					ent_we         = 1'b1;
					if (pl.valid) begin
						unique case (lm)
							LM_LOW, LM_FALLING: fire = !nv;
							LM_HIGH, LM_RISING: fire = nv;
							LM_CHANGE:          fire = 1'b1;
							LM_NONE:            fire = 1'b0;
							default:            fire = 1'b0;
						endcase
					end
				end
				REQ_SERVICE: pop = (count_q != '0);
				default: ;
			endcase
		end
		fire    = fire && process;
		pop     = pop && process;
		ent_we  = ent_we && process;
	end

	assign push    = fire && (count_q != CNT_W'(QUEUE_DEPTH));
	assign dropped = fire && (count_q == CNT_W'(QUEUE_DEPTH));

	always_comb begin
		count_d = count_q;
		priority if (push)
			count_d = count_q + 1'b1;
		else if (pop)
			count_d = count_q - 1'b1;
	end

	// pin table memory with write-first read
	always_ff @(posedge clk) begin
		if (ent_we)
			pin_mem[waddr] <= ent_nxt;
		if (accept) begin
			if (ent_we && waddr == raddr)
				ent_s1 <= ent_nxt;
			else
				ent_s1 <= pin_mem[raddr];
		end
	end

	// event queue memory; head entry prefetched
	always_ff @(posedge clk) begin
		if (push)
			fifo_mem[tail_q] <= pl.line;
		if (push && tail_q == head_nxt)
			fifo_rd_q <= pl.line;
		else
			fifo_rd_q <= fifo_mem[head_nxt];
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1   <= req_type_t'(req.req_type);
			pin_s1   <= req.pin_index;
			nmode_s1 <= pin_mode_t'(req.new_mode);
			val_s1   <= req.write_value;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (process) begin
			status_q  <= status;
			rlevel_q  <= rlevel;
			ranalog_q <= ranalog;
			ivalid_q  <= pop;
			iline_q   <= pop ? fifo_rd_q : '0;
			dropped_q <= dropped;
			pending_q <= COUNT_W'(count_d);
			pl_q      <= pl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_modes_q <= '0;
			valid_s1     <= 1'b0;
			ent_vld_s1   <= 1'b0;
			pin_vld_q    <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we)
				line_modes_q <= cfg_wdata;
			if (req.ready)
				valid_s1 <= req.valid;
			if (accept)
				ent_vld_s1 <= pin_vld_q[raddr] || (ent_we && waddr == raddr);
			if (ent_we)
				pin_vld_q[waddr] <= 1'b1;
			if (push)
				tail_q <= tail_inc;
			if (pop)
				head_q <= head_inc;
			count_q <= count_d;
			if (adv)
				out_valid_q <= valid_s1;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = status_q;
	assign rsp.read_level     = rlevel_q;
	assign rsp.read_is_analog = ranalog_q;
	assign rsp.irq_valid      = ivalid_q;
	assign rsp.irq_line       = iline_q;
	assign rsp.irq_dropped    = dropped_q;
	assign rsp.pending_count  = pending_q;
	assign rsp.pin_line_valid = pl_q.valid;
	assign rsp.pin_line       = pl_q.line;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("event count above queue depth");

	a_drop_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		dropped |-> count_q == CNT_W'(QUEUE_DEPTH) && !push)
		else $error("event dropped while queue had room");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ent_we |-> in_range && process)
		else $error("pin table written for out-of-range pin");

	a_pop_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.irq_valid |-> rsp.status == ST_OK && !rsp.irq_dropped)
		else $error("popped event reported with error or drop");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(pin_s1) && $stable(count_q))
		else $error("stage 1 or queue changed while stalled");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for gpio_bank_with_pin_interrupts: mirrors the pin table, line modes and
// event queue, and drives directed then random requests with random idling on both channels.
// Depends on gpio_irq_pkg, gpio_irq_req_if, gpio_irq_rsp_if and the top level.
module tb
	import gpio_irq_pkg::*;
();

	localparam int unsigned PIN_COUNT   = 64;
	localparam int unsigned FIFO_DEPTH  = 16;
	localparam int unsigned RSP_LATENCY = 2;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam logic [2:0]  REQ_SPARE6  = 3'd6;
	localparam logic [2:0]  REQ_SPARE7  = 3'd7;
	localparam logic [2:0]  LM_SPARE7   = 3'd7;

	typedef struct packed {
		logic [2:0]         kind;
		logic [PIN_W-1:0]   pin;
		logic [1:0]         mode;
		logic [VALUE_W-1:0] value;
	} pin_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [LEVEL_W-1:0] read_level;
		logic               read_is_analog;
		logic               irq_valid;
		logic [LINE_W-1:0]  irq_line;
		logic               irq_dropped;
		logic [COUNT_W-1:0] pending_count;
		logic               pin_line_valid;
		logic [LINE_W-1:0]  pin_line;
	} pin_rsp_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [MODES_W-1:0] cfg_wdata;

	gpio_irq_req_if req();
	gpio_irq_rsp_if rsp();

	gpio_bank_with_pin_interrupts #(
		.NUM_PINS(PIN_COUNT),
		.QUEUE_DEPTH(FIFO_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	logic [1:0]         pin_modes  [PIN_COUNT] = '{default: PM_NONE};
	logic [LEVEL_W-1:0] pin_levels [PIN_COUNT] = '{default: '0};
	logic               pin_analog [PIN_COUNT] = '{default: 1'b0};
	logic [LINE_W-1:0]  pending_events [$];
	logic [MODES_W-1:0] line_modes_now = '0;
	pin_rsp_t           awaited_results [$];
	logic [PIN_W-1:0]   irq_pins [NUM_LINES] =
		'{PIN_LINE0, PIN_LINE1, PIN_LINE2, PIN_LINE3, PIN_LINE4, PIN_LINE5};

	int fails = 0;
	int stall_left = 0;
	int cycle_count = 0;
	bit steady = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int line_for_pin(logic [PIN_W-1:0] p);
		case (p)
			PIN_LINE0: return 0;
			PIN_LINE1: return 1;
			PIN_LINE2: return 2;
			PIN_LINE3: return 3;
			PIN_LINE4: return 4;
			PIN_LINE5: return 5;
			default:   return -1;
		endcase
	endfunction

	function automatic logic [MODES_W-1:0] uniform_modes(logic [2:0] m);
		return {NUM_LINES{m}};
	endfunction

	function automatic pin_rsp_t emulate_pin_request(pin_req_t r);
		pin_rsp_t o;
		int ln;
		int v;
		logic [LEVEL_W-1:0] nv;
		logic [2:0] lm;
		logic fire;
		o = '0;
		ln = line_for_pin(r.pin);
		v = $signed(r.value);
		fire = 1'b0;
		if (ln >= 0) begin
			o.pin_line_valid = 1'b1;
			o.pin_line = LINE_W'(ln);
		end
		if (r.kind <= REQ_TOGGLE && r.pin >= PIN_COUNT) begin
			o.status = ST_RANGE;
		end else begin
			case (r.kind)
				REQ_SET_MODE: begin
					pin_modes[r.pin] = r.mode;
					if (r.mode == PM_PULLUP)
						pin_levels[r.pin] = pin_analog[r.pin] ? '0 :
							LEVEL_W'(pin_levels[r.pin] == 0);
				end
				REQ_DIG_WR: begin
					if (pin_modes[r.pin] != PM_OUTPUT) begin
						o.status = ST_BAD_MODE;
					end else if (v != 0 && v != 1) begin
						o.status = ST_BAD_VALUE;
					end else begin
						pin_levels[r.pin] = LEVEL_W'(v);
						pin_analog[r.pin] = 1'b0;
					end
				end
				REQ_READ: begin
					if (pin_modes[r.pin] != PM_INPUT && pin_modes[r.pin] != PM_PULLUP) begin
						o.status = ST_BAD_MODE;
					end else begin
						o.read_level = pin_levels[r.pin];
						o.read_is_analog = pin_analog[r.pin];
					end
				end
				REQ_ANA_WR: begin
					if (pin_modes[r.pin] != PM_OUTPUT) begin
						o.status = ST_BAD_MODE;
					end else begin
						if (v < 0)
							pin_levels[r.pin] = '0;
						else if (v > int'(LEVEL_MAX))
							pin_levels[r.pin] = LEVEL_W'(LEVEL_MAX);
						else
							pin_levels[r.pin] = LEVEL_W'(v);
						pin_analog[r.pin] = 1'b1;
					end
				end
				REQ_TOGGLE: begin
					nv = LEVEL_W'(pin_levels[r.pin] == 0);
					pin_levels[r.pin] = nv;
					pin_analog[r.pin] = 1'b0;
					if (ln >= 0) begin
						lm = line_modes_now[LINE_W*ln +: LINE_W];
						case (lm)
							LM_LOW, LM_FALLING: fire = (nv == 0);
							LM_HIGH, LM_RISING: fire = (nv == 1);
							LM_CHANGE:          fire = 1'b1;
							default:            fire = 1'b0;
						endcase
						if (fire) begin
							if (pending_events.size() >= FIFO_DEPTH)
								o.irq_dropped = 1'b1;
							else
								pending_events.push_back(LINE_W'(ln));
						end
					end
				end
				REQ_SERVICE: begin
					if (pending_events.size() > 0) begin
						o.irq_valid = 1'b1;
						o.irq_line = pending_events.pop_front();
					end
				end
				default: ;
			endcase
		end
		o.pending_count = COUNT_W'(pending_events.size());
		return o;
	endfunction

	function automatic pin_req_t mk_req(logic [2:0] kind, logic [PIN_W-1:0] pin,
		logic [1:0] mode, logic [VALUE_W-1:0] value);
		pin_req_t r;
		r.kind = kind;
		r.pin = pin;
		r.mode = mode;
		r.value = value;
		return r;
	endfunction

	function automatic pin_req_t random_request();
		pin_req_t r;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 5)
			r.pin = irq_pins[$urandom_range(0, NUM_LINES-1)];
		else if (pick < 7)
			r.pin = $urandom_range(0, 1) ? PIN_W'($urandom_range(0, 1)) :
				PIN_W'($urandom_range(PIN_COUNT-2, PIN_COUNT-1));
		else
			r.pin = PIN_W'($urandom_range(0, PIN_COUNT-1));
		r.mode = 2'($urandom_range(0, 3));
		r.value = VALUE_W'($urandom());
		pick = $urandom_range(0, 99);
		if (pick < 14) begin
			r.kind = REQ_SET_MODE;
		end else if (pick < 28) begin
			r.kind = REQ_DIG_WR;
			if ($urandom_range(0, 3) != 0)
				r.value = VALUE_W'($urandom_range(0, 1));
		end else if (pick < 42) begin
			r.kind = REQ_READ;
		end else if (pick < 52) begin
			r.kind = REQ_ANA_WR;
			if ($urandom_range(0, 4) < 3)
				r.value = VALUE_W'(int'($urandom_range(0, 300)) - 20);
		end else if (pick < 77) begin
			r.kind = REQ_TOGGLE;
		end else if (pick < 95) begin
			r.kind = REQ_SERVICE;
		end else begin
			r.kind = $urandom_range(0, 1) ? REQ_SPARE6 : REQ_SPARE7;
		end
		return r;
	endfunction

	function automatic logic [MODES_W-1:0] random_edge_modes();
		logic [MODES_W-1:0] m;
		for (int i = 0; i < NUM_LINES; i++)
			m[LINE_W*i +: LINE_W] = LINE_W'($urandom_range(1, 7));
		return m;
	endfunction

	function automatic int idle_gap();
		int pick;
		if (steady)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_request(pin_req_t r);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= r.kind;
		req.pin_index <= r.pin;
		req.new_mode <= r.mode;
		req.write_value <= r.value;
		do @(posedge clk); while (!req.ready);
		awaited_results.push_back(emulate_pin_request(r));
	endtask

	task automatic settle();
		req.valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (RSP_LATENCY + 1) @(posedge clk);
	endtask

	task automatic write_line_modes(logic [MODES_W-1:0] modes);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= modes;
		@(posedge clk);
		cfg_we <= 1'b0;
		line_modes_now = modes;
	endtask

	task automatic test_directed();
		send_request(mk_req(REQ_READ, 0, PM_NONE, 16'h0000));
		send_request(mk_req(REQ_SET_MODE, 0, PM_OUTPUT, 16'h0000));
		send_request(mk_req(REQ_DIG_WR, 0, PM_NONE, 16'h0001));
		send_request(mk_req(REQ_DIG_WR, 0, PM_NONE, 16'h0002));
		send_request(mk_req(REQ_DIG_WR, 0, PM_NONE, 16'h8000));
		send_request(mk_req(REQ_SET_MODE, 0, PM_PULLUP, 16'hffff));
		send_request(mk_req(REQ_READ, 0, PM_NONE, 16'h0000));
		send_request(mk_req(REQ_DIG_WR, 0, PM_NONE, 16'h0001));
		send_request(mk_req(REQ_ANA_WR, 63, PM_NONE, 16'h0010));
		send_request(mk_req(REQ_SET_MODE, 63, PM_OUTPUT, 16'h0000));
		send_request(mk_req(REQ_ANA_WR, 63, PM_NONE, 16'hffff));
		send_request(mk_req(REQ_ANA_WR, 63, PM_NONE, 16'h7fff));
		send_request(mk_req(REQ_ANA_WR, 63, PM_NONE, 16'h00ff));
		send_request(mk_req(REQ_ANA_WR, 63, PM_NONE, 16'h0080));
		send_request(mk_req(REQ_SET_MODE, 63, PM_INPUT, 16'h0000));
		send_request(mk_req(REQ_READ, 63, PM_NONE, 16'h0000));
		send_request(mk_req(REQ_SET_MODE, 63, PM_PULLUP, 16'h0000));
		send_request(mk_req(REQ_READ, 63, PM_NONE, 16'h0000));
		send_request(mk_req(REQ_TOGGLE, 63, PM_NONE, 16'h0000));
		send_request(mk_req(REQ_SERVICE, 5, PM_NONE, 16'h0000));
		send_request(mk_req(REQ_TOGGLE, PIN_LINE0, PM_NONE, 16'h0000));
		send_request(mk_req(REQ_SPARE6, PIN_LINE5, PM_PULLUP, 16'h8000));
		send_request(mk_req(REQ_SPARE7, PIN_LINE4, PM_OUTPUT, 16'h7fff));
		write_line_modes(uniform_modes(LM_SPARE7));
		send_request(mk_req(REQ_TOGGLE, PIN_LINE1, PM_NONE, 16'h0000));
		write_line_modes(uniform_modes(LM_CHANGE));
		send_request(mk_req(REQ_TOGGLE, PIN_LINE5, PM_NONE, 16'h0000));
		send_request(mk_req(REQ_SERVICE, 0, PM_NONE, 16'h0000));
	endtask

	task automatic test_mixed_phases();
		logic [MODES_W-1:0] setting;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0:       setting = uniform_modes(LM_NONE);
				1:       setting = uniform_modes(LM_SPARE7);
				2:       setting = uniform_modes(LM_CHANGE);
				default: setting = MODES_W'($urandom());
			endcase
			write_line_modes(setting);
			repeat (140) send_request(random_request());
		end
	endtask

	task automatic test_irq_storm();
		pin_req_t r;
		int bursts;
		repeat (8) begin
			write_line_modes(random_edge_modes());
			bursts = $urandom_range(10, 40);
			repeat (bursts) begin
				r = random_request();
				r.kind = $urandom_range(0, 7) == 0 ? REQ_SERVICE : REQ_TOGGLE;
				r.pin = irq_pins[$urandom_range(0, NUM_LINES-1)];
				send_request(r);
			end
			repeat (FIFO_DEPTH + 4) begin
				r = random_request();
				r.kind = REQ_SERVICE;
				send_request(r);
			end
		end
	endtask

	task automatic test_back_to_back();
		write_line_modes(random_edge_modes());
		steady = 1'b1;
		repeat (250) send_request(random_request());
		settle();
		steady = 1'b0;
	endtask

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		pin_rsp_t want;
		if (rsp.valid && rsp.ready) begin
			if (awaited_results.size() == 0) begin
				$error("result with no request outstanding");
				fails++;
			end else begin
				want = awaited_results.pop_front();
				check_field("status", want.status, rsp.status);
				check_field("read_level", want.read_level, rsp.read_level);
				check_field("read_is_analog", want.read_is_analog, rsp.read_is_analog);
				check_field("irq_valid", want.irq_valid, rsp.irq_valid);
				check_field("irq_line", want.irq_line, rsp.irq_line);
				check_field("irq_dropped", want.irq_dropped, rsp.irq_dropped);
				check_field("pending_count", want.pending_count, rsp.pending_count);
				check_field("pin_line_valid", want.pin_line_valid, rsp.pin_line_valid);
				check_field("pin_line", want.pin_line, rsp.pin_line);
			end
		end
		if (steady || stall_left == 0) begin
			rsp.ready <= 1'b1;
			if (!steady && $urandom_range(0, 3) == 0)
				stall_left = idle_gap();
		end else begin
			rsp.ready <= 1'b0;
			stall_left--;
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req.valid <= 1'b0;
		req.req_type <= REQ_SET_MODE;
		req.pin_index <= '0;
		req.new_mode <= PM_NONE;
		req.write_value <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_mixed_phases();
		test_irq_storm();
		test_back_to_back();
		settle();
		if (fails == 0 && awaited_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/gpio_irq_pkg.sv
rtl/gpio_irq_req_if.sv
rtl/gpio_irq_rsp_if.sv
rtl/gpio_bank_with_pin_interrupts.sv
bench/tb.sv
